// ----- rtl/core/cqsd_pkg.sv -----
// Shared types, constants and helper functions for the quoted string decoder.
// Used by cqsd_decode and css_quoted_string_decoder_unit; depends on nothing.
`default_nettype none

package cqsd_pkg;

  localparam int MaxHexDigits = 6;
  localparam int HexCntW      = 3;
  localparam int MaxRes       = 5;
  localparam int ResCntW      = 3;
  localparam int CpW          = 21;

  localparam logic [7:0]  CharDquote = 8'h22;
  localparam logic [7:0]  CharSquote = 8'h27;
  localparam logic [7:0]  CharBslash = 8'h5C;
  localparam logic [20:0] CpReplace  = 21'h00FFFD;
  localparam logic [23:0] SurrLo     = 24'h00D800;
  localparam logic [23:0] SurrHi     = 24'h00DFFF;
  localparam logic [23:0] CpMax      = 24'h10FFFF;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_BODY,
    MODE_ESC,
    MODE_HEX
  } mode_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_NO_OPEN,
    ERR_UNTERM
  } err_e;

  typedef struct packed {
    mode_e                mode;
    logic                 dquote;
    logic [23:0]          hex;
    logic [HexCntW-1:0]   hex_cnt;
  } state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       done;
    err_e       err;
  } res_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
  } utf8_t;

  function automatic logic is_newline(input logic [7:0] b);
    return (b == 8'h0A) || (b == 8'h0D) || (b == 8'h0C);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || is_newline(b);
  endfunction

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_of(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

  function automatic utf8_t utf8_enc(input logic [CpW-1:0] cp);
    utf8_t u;
    u = '0;
    if (cp < 21'h80) begin
      u.cnt      = 3'd1;
      u.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      u.cnt      = 3'd2;
      u.bytes[0] = {3'b110, cp[10:6]};
      u.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      u.cnt      = 3'd3;
      u.bytes[0] = {4'b1110, cp[15:12]};
      u.bytes[1] = {2'b10, cp[11:6]};
      u.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      u.cnt      = 3'd4;
      u.bytes[0] = {5'b11110, cp[20:18]};
      u.bytes[1] = {2'b10, cp[17:12]};
      u.bytes[2] = {2'b10, cp[11:6]};
      u.bytes[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cqsd_decode.sv -----
// Combinational decode of one source byte against the parser state.
// Produces the next state and up to five result beats; uses cqsd_pkg.
`default_nettype none

module cqsd_decode
  import cqsd_pkg::*;
(
  input  state_t                   state_i,
  input  logic [7:0]               in_byte_i,
  input  logic                     eoi_i,
  output state_t                   state_o,
  output res_t [MaxRes-1:0]        res_o,
  output logic [ResCntW-1:0]       res_cnt_o
);

  always_comb begin
    state_t             nst;
    res_t [MaxRes-1:0]  res;
    logic [ResCntW-1:0] n;
    logic               emit_cp;
    logic [CpW-1:0]     cp;
    logic               do_body;
    logic [4:0]         hx;
    logic               bad;
    logic [7:0]         qch;
    res_t               body_res;
    logic               body_put;
    utf8_t              u;

    nst      = state_i;
    res      = '0;
    n        = '0;
    emit_cp  = 1'b0;
    cp       = '0;
    do_body  = 1'b0;
    hx       = hex_of(in_byte_i);
    bad      = (state_i.hex == 24'd0) ||
               (state_i.hex >= SurrLo && state_i.hex <= SurrHi) ||
               (state_i.hex > CpMax);
    qch      = state_i.dquote ? CharDquote : CharSquote;
    body_res = '0;
    body_put = 1'b0;
    u        = '0;

    unique case (state_i.mode)
      MODE_BODY: begin
        if (eoi_i) begin
          res[0].err = ERR_UNTERM;
          n          = 3'd1;
          nst.mode   = MODE_IDLE;
        end else begin
          do_body = 1'b1;
        end
      end
      MODE_ESC: begin
        if (eoi_i) begin
          res[0].err = ERR_UNTERM;
          n          = 3'd1;
          nst.mode   = MODE_IDLE;
        end else if (is_newline(in_byte_i)) begin
          nst.mode = MODE_BODY;
        end else if (hx[4]) begin
          nst.hex     = {20'd0, hx[3:0]};
          nst.hex_cnt = 3'd1;
          nst.mode    = MODE_HEX;
        end else begin
          emit_cp  = 1'b1;
          cp       = (in_byte_i == 8'd0) ? CpReplace : {13'd0, in_byte_i};
          nst.mode = MODE_BODY;
        end
      end
      MODE_HEX: begin
        if (eoi_i) begin
          res[0].err = ERR_UNTERM;
          n          = 3'd1;
          nst.mode   = MODE_IDLE;
        end else if (hx[4] && state_i.hex_cnt < HexCntW'(MaxHexDigits)) begin
          nst.hex     = {state_i.hex[19:0], hx[3:0]};
          nst.hex_cnt = state_i.hex_cnt + 3'd1;
        end else begin
          emit_cp     = 1'b1;
          cp          = bad ? CpReplace : state_i.hex[CpW-1:0];
          nst.hex     = '0;
          nst.hex_cnt = '0;
          nst.mode    = MODE_BODY;
          do_body     = !is_space(in_byte_i);
        end
      end
      default: begin
        nst.mode = MODE_IDLE;
        if (!eoi_i && (in_byte_i == CharDquote || in_byte_i == CharSquote)) begin
          nst.dquote = (in_byte_i == CharDquote);
          nst.mode   = MODE_BODY;
        end else begin
          res[0].err = ERR_NO_OPEN;
          n          = 3'd1;
        end
      end
    endcase

    if (emit_cp) begin
      u = utf8_enc(cp);
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < u.cnt) begin
          res[i].data = u.bytes[i];
          res[i].vld  = 1'b1;
        end
      end
      n = u.cnt;
    end

    if (do_body) begin
      if (in_byte_i == qch) begin
        body_res.done = 1'b1;
        body_put      = 1'b1;
        nst.mode      = MODE_IDLE;
      end else if (in_byte_i == 8'd0 || is_newline(in_byte_i)) begin
        body_res.err = ERR_UNTERM;
        body_put     = 1'b1;
        nst.mode     = MODE_IDLE;
      end else if (in_byte_i == CharBslash) begin
        nst.mode = MODE_ESC;
      end else begin
        body_res.data = in_byte_i;
        body_res.vld  = 1'b1;
        body_put      = 1'b1;
        nst.mode      = MODE_BODY;
      end
    end

    if (body_put) begin
      for (int i = 0; i < MaxRes; i++) begin
        if (3'(i) == n) begin
          res[i] = body_res;
        end
      end
      n = n + 3'd1;
    end

    state_o   = nst;
    res_o     = res;
    res_cnt_o = n;
  end

endmodule

`default_nettype wire

// ----- rtl/core/css_quoted_string_decoder_unit.sv -----
// Top level of the quoted CSS string decoder: input register, decode, result buffer.
// Depends on cqsd_pkg and cqsd_decode.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o  in_byte_i, end_of_input_i
//   out      source     out_valid_o / out_stall_i out_byte_o, byte_valid_o,
//                                               string_done_o, error_code_o,
//                                               last_of_run_o
//
// A byte is decoded combinationally from the input register; its results land in a
// five-entry result buffer, which sends one beat per cycle unless out_stall_i is high.
// Without stalls, a byte giving zero or one beat keeps the rate at one byte per cycle;
// a byte giving more beats holds the input, as the result buffer has one output port.
// Reset returns the parser to idle, awaiting an opening quote, with both stages empty.
// Output stalls back up into the input register and then onto in_stall_o.
`default_nettype none

module css_quoted_string_decoder_unit
  import cqsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       string_done_o,
  output logic [1:0] error_code_o,
  output logic       last_of_run_o
);

  logic                in_vld_q, in_vld_d;
  logic [7:0]          in_byte_q;
  logic                in_eoi_q;
  state_t              state_q, state_d;
  res_t [MaxRes-1:0]   res_q, res_d;
  logic [ResCntW-1:0]  res_cnt_q, res_cnt_d;
  logic [ResCntW-1:0]  rd_idx_q, rd_idx_d;
  logic [ResCntW-1:0]  rd_idx_inc;
  state_t              dec_state;
  res_t [MaxRes-1:0]   dec_res;
  logic [ResCntW-1:0]  dec_cnt;
  logic                in_acc, out_take, buf_free, adv;
  res_t                cur;

  cqsd_decode u_decode (
    .state_i   (state_q),
    .in_byte_i (in_byte_q),
    .eoi_i     (in_eoi_q),
    .state_o   (dec_state),
    .res_o     (dec_res),
    .res_cnt_o (dec_cnt)
  );

  assign rd_idx_inc  = rd_idx_q + 3'd1;
  assign out_valid_o = (rd_idx_q != res_cnt_q);
  assign out_take    = out_valid_o && !out_stall_i;
  assign buf_free    = !out_valid_o || (out_take && (rd_idx_inc == res_cnt_q));
  assign adv         = in_vld_q && buf_free;
  assign in_stall_o  = in_vld_q && !adv;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_vld_d    = in_acc || (in_vld_q && !adv);

  assign state_d   = adv ? dec_state : state_q;
  assign res_d     = adv ? dec_res : res_q;
  assign res_cnt_d = adv ? dec_cnt : res_cnt_q;
  assign rd_idx_d  = adv ? '0 : (out_take ? rd_idx_inc : rd_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      state_q   <= '{mode: MODE_IDLE, dquote: 1'b0, hex: '0, hex_cnt: '0};
      res_cnt_q <= '0;
      rd_idx_q  <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      state_q   <= state_d;
      res_cnt_q <= res_cnt_d;
      rd_idx_q  <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= in_byte_i;
      in_eoi_q  <= end_of_input_i;
    end
    res_q <= res_d;
  end

  assign cur           = res_q[rd_idx_q];
  assign out_byte_o    = cur.data;
  assign byte_valid_o  = cur.vld;
  assign string_done_o = cur.done;
  assign error_code_o  = cur.err;
  assign last_of_run_o = (rd_idx_inc == res_cnt_q);

`ifndef SYNTH
  a_buf_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_cnt_q <= 3'(MaxRes)) && (rd_idx_q <= res_cnt_q))
    else $error("result buffer count or read index out of range");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && string_done_o) |-> (last_of_run_o && !byte_valid_o))
    else $error("closing quote beat is not the last beat of its byte");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (error_code_o != ERR_NONE)) |-> (last_of_run_o && !byte_valid_o))
    else $error("error beat is not a lone final beat");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (dec_cnt != 3'd0) && dec_res[dec_cnt - 3'd1].done) |=>
      (state_q.mode == MODE_IDLE))
    else $error("parser did not return to idle after closing quote");
`endif

endmodule

`default_nettype wire
